// ===== rtl/fdc_pkg.sv =====
// Shared types and constants for the factorial divisibility checker.
package fdc_pkg;

	// Default operand width
	localparam int VALUE_BITS_DEF = 31;

	// First trial divisor and first odd trial divisor
	localparam int FIRST_PRIME = 2;
	localparam int FIRST_ODD   = 3;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STRIP,
		ST_LEG_N,
		ST_LEG,
		ST_FINAL,
		ST_WRITE
	} fdc_state_t;

	// Dividend select for the shared divider
	typedef enum logic [1:0] {
		DIVD_REST,
		DIVD_N,
		DIVD_QUOT
	} fdc_divd_t;

	// Divisor select for the shared divider
	typedef enum logic {
		DIVS_D,
		DIVS_P
	} fdc_divs_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      load;
		logic      div_start;
		fdc_divd_t div_src;
		fdc_divs_t dvs_sel;
		logic      strip_take;
		logic      leg_init;
		logic      leg_init_rest;
		logic      leg_acc;
		logic      next_d;
		logic      out_load;
		logic      out_value;
	} fdc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic m_zero;
		logic div_busy;
		logic div_done;
		logic rem_zero;
		logic quot_zero;
		logic d_gt_q;
		logic d_is2;
		logic e_nonzero;
		logic sum_ge_e;
		logic rest_gt1;
	} fdc_sts_t;

endpackage

// ===== rtl/factorial_divisibility_check_top.sv =====
// Each division runs on the shared divider; each trial candidate passes through a check state
// (ST_CHECK) and each prime through a setup state (ST_LEG_N) before its sums.
// Worst case is m a prime near 2^31: about 23170 trial candidates at 31 bits.
// Throughput: one item at a time; the next beat is taken once the result sits in the
// output register. Reset (arst_n low, asynchronous) clears the controller, divider control
// and output valid; operand and payload registers are not reset.
module factorial_divisibility_check_top import fdc_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] factorial_base,
	input  logic [VALUE_BITS-1:0] divisor_candidate,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  divides
);

	fdc_cmd_t cmd;
	fdc_sts_t sts;

	fdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fdc_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.factorial_base   (factorial_base),
		.divisor_candidate(divisor_candidate),
		.sts              (sts),
		.divides          (divides)
	);

`ifndef SYNTH
	// The divider is never restarted mid-division
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	// A pending result beat is never overwritten
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result overwritten before taken");

	// After an input beat the block is busy with it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while item in progress");
`endif

endmodule

// ===== rtl/fdc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fdc_div import fdc_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [VALUE_BITS-1:0] remainder
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] dvs_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS:0]   shifted;
	logic [VALUE_BITS:0]   diff;

	// One trial subtraction
	always_comb begin
		shifted = {rem_q, quo_q[VALUE_BITS-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	// Control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and result shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[VALUE_BITS]) begin
				rem_q <= diff[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/fdc_dp.sv =====
// Datapath: operand registers, exponent and Legendre sum, shared divider.
module fdc_dp import fdc_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fdc_cmd_t              cmd,
	input  logic [VALUE_BITS-1:0] factorial_base,
	input  logic [VALUE_BITS-1:0] divisor_candidate,
	output fdc_sts_t              sts,
	output logic                  divides
);

	localparam int EW = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] rest_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS-1:0] p_q;
	logic [EW-1:0]         e_q;
	logic [VALUE_BITS:0]   sum_q;
	logic                  divides_q;

	logic [VALUE_BITS-1:0] div_a;
	logic [VALUE_BITS-1:0] div_b;
	logic [VALUE_BITS-1:0] quot;
	logic [VALUE_BITS-1:0] rem;
	logic                  div_busy;
	logic                  div_done;

	// Divider operand select
	always_comb begin
		case (cmd.div_src)
			DIVD_REST: div_a = rest_q;
			DIVD_N:    div_a = n_q;
			DIVD_QUOT: div_a = quot;
			default:   div_a = rest_q;
		endcase
		div_b = (cmd.dvs_sel == DIVS_P) ? p_q : d_q;
	end

	fdc_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot),
		.remainder(rem)
	);

	// Operand, candidate and exponent registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= factorial_base;
			rest_q <= divisor_candidate;
			d_q    <= VALUE_BITS'(FIRST_PRIME);
			e_q    <= '0;
		end else begin
			if (cmd.strip_take) begin
				rest_q <= quot;
				e_q    <= e_q + 1'b1;
			end
			if (cmd.next_d) begin
				d_q <= sts.d_is2 ? VALUE_BITS'(FIRST_ODD) : d_q + VALUE_BITS'(2);
				e_q <= '0;
			end
			if (cmd.leg_init_rest)
				e_q <= EW'(1);
		end
	end

	// Legendre sum: prime under test and running sum
	always_ff @(posedge clk) begin
		if (cmd.leg_init) begin
			p_q   <= d_q;
			sum_q <= '0;
		end else if (cmd.leg_init_rest) begin
			p_q   <= rest_q;
			sum_q <= '0;
		end else if (cmd.leg_acc) begin
			sum_q <= sum_q + {1'b0, quot};
		end
	end

	// Result beat payload
	always_ff @(posedge clk) begin
		if (cmd.out_load)
			divides_q <= cmd.out_value;
	end

	// Status back to the controller
	always_comb begin
		sts.m_zero    = (rest_q == '0);
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.rem_zero  = (rem == '0);
		sts.quot_zero = (quot == '0);
		sts.d_gt_q    = (d_q > quot);
		sts.d_is2     = (d_q == VALUE_BITS'(FIRST_PRIME));
		sts.e_nonzero = (e_q != '0);
		sts.sum_ge_e  = (sum_q >= (VALUE_BITS+1)'(e_q));
		sts.rest_gt1  = (rest_q > VALUE_BITS'(1));
	end

	assign divides = divides_q;

endmodule

// ===== rtl/fdc_ctrl.sv =====
// Controller: sequences trial division and Legendre sums over the datapath.
module fdc_ctrl import fdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  fdc_sts_t sts,
	output fdc_cmd_t cmd
);

	fdc_state_t st_q;
	fdc_state_t st_nxt;
	logic       verdict_q;
	logic       final_q;
	logic       out_valid_q;
	logic       check_exit;
	logic       leg_stop;
	logic       out_free;

	// Loop exits: candidate past the square root, Legendre sum finished
	assign check_exit = !sts.d_is2 && !sts.e_nonzero && sts.d_gt_q;
	assign leg_stop   = sts.quot_zero || sts.sum_ge_e;
	assign out_free   = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE:  if (in_valid) begin
				st_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				st_nxt = sts.m_zero ? ST_WRITE : ST_STRIP;
			end
			ST_STRIP: if (sts.div_done) begin
				if (check_exit)
					st_nxt = ST_FINAL;
				else if (sts.rem_zero)
					st_nxt = ST_STRIP;
				else if (sts.e_nonzero)
					st_nxt = ST_LEG_N;
				else
					st_nxt = ST_CHECK;
			end
			ST_LEG_N: begin
				st_nxt = ST_LEG;
			end
			ST_LEG:   if (sts.div_done && leg_stop) begin
				if (!sts.sum_ge_e || final_q)
					st_nxt = ST_WRITE;
				else
					st_nxt = ST_CHECK;
			end
			ST_FINAL: begin
				st_nxt = sts.rest_gt1 ? ST_LEG_N : ST_WRITE;
			end
			ST_WRITE: if (out_free) begin
				st_nxt = ST_IDLE;
			end
			default:  st_nxt = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd           = '0;
		cmd.div_src   = DIVD_REST;
		cmd.dvs_sel   = DIVS_D;
		cmd.out_value = verdict_q;
		in_stall      = 1'b1;
		case (st_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_CHECK: begin
				cmd.div_start = !sts.m_zero;
			end
			ST_STRIP: if (sts.div_done && !check_exit) begin
				if (sts.rem_zero) begin
					cmd.strip_take = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.div_src    = DIVD_QUOT;
				end else if (sts.e_nonzero) begin
					cmd.leg_init = 1'b1;
				end else begin
					cmd.next_d = 1'b1;
				end
			end
			ST_LEG_N: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = DIVD_N;
				cmd.dvs_sel   = DIVS_P;
			end
			ST_LEG: if (sts.div_done) begin
				if (!leg_stop) begin
					cmd.leg_acc   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_src   = DIVD_QUOT;
					cmd.dvs_sel   = DIVS_P;
				end else if (sts.sum_ge_e && !final_q) begin
					cmd.next_d = 1'b1;
				end
			end
			ST_FINAL: begin
				cmd.leg_init_rest = sts.rest_gt1;
			end
			ST_WRITE: begin
				cmd.out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_nxt;
	end

	// Verdict and last-prime flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q <= 1'b0;
			final_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				verdict_q <= 1'b1;
				final_q   <= 1'b0;
			end else if (st_q == ST_CHECK && sts.m_zero) begin
				verdict_q <= 1'b0;
			end else if (st_q == ST_LEG && sts.div_done && leg_stop && !sts.sum_ge_e) begin
				verdict_q <= 1'b0;
			end
			if (st_q == ST_FINAL)
				final_q <= 1'b1;
		end
	end

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

endmodule
